FILE: design/thompson_nfa_builder_and_closure_macros.svh
// Assertion macros for the Thompson NFA builder.
`ifndef THOMPSON_NFA_BUILDER_AND_CLOSURE_MACROS_SVH
`define THOMPSON_NFA_BUILDER_AND_CLOSURE_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define TNFA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define TNFA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/tnfa_pkg.sv
// Constants, codes and widths shared by the Thompson NFA builder.
package tnfa_pkg;
   localparam int MAX_STATES  = 64;
   localparam int STACK_DEPTH = 32;
   localparam int STATE_W     = 6;
   localparam int PAIR_W      = 2 * STATE_W;
   localparam int IDX_W       = $clog2(MAX_STATES);
   localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
   localparam int CNT_W       = 7;
   localparam int SET_W       = 64;
   localparam int SYM_W       = 9;

   localparam logic [SET_W-1:0] STATE_MASK = (MAX_STATES >= SET_W) ? {SET_W{1'b1}} :
      ((SET_W'(1) << MAX_STATES) - SET_W'(1));

   typedef logic [2:0]         mode_type;
   typedef logic [2:0]         status_type;
   typedef logic [7:0]         char_type;
   typedef logic [SET_W-1:0]   set_type;
   typedef logic [STATE_W-1:0] state_id_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [PAIR_W-1:0]  pair_type;

   localparam mode_type MODE_CHAR   = 3'd0;
   localparam mode_type MODE_FINISH = 3'd1;
   localparam mode_type MODE_CLEAR  = 3'd2;
   localparam mode_type MODE_CLOS   = 3'd3;
   localparam mode_type MODE_MOVE   = 3'd4;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_UNDER     = 3'd1;
   localparam status_type ST_STATE_OVF = 3'd2;
   localparam status_type ST_STACK_OVF = 3'd3;
   localparam status_type ST_FAIL      = 3'd4;

   localparam char_type CH_ALT  = 8'h7c;
   localparam char_type CH_CAT  = 8'h2e;
   localparam char_type CH_STAR = 8'h2a;
   localparam char_type CH_PLUS = 8'h2b;
   localparam char_type CH_OPT  = 8'h3f;
   localparam char_type CH_EPS  = 8'h23;
   localparam char_type CH_ESC  = 8'h5c;
endpackage

FILE: design/tnfa_ifc.sv
// Request and response channel interfaces of the Thompson NFA builder.
interface tnfa_req_if;
   import tnfa_pkg::*;
   logic       valid;
   logic       ready;
   mode_type   mode;
   char_type   token_char;
   set_type    state_set;
   modport source (output valid, mode, token_char, state_set, input ready);
   modport sink (input valid, mode, token_char, state_set, output ready);
endinterface

interface tnfa_rsp_if;
   import tnfa_pkg::*;
   logic         valid;
   logic         ready;
   status_type   status;
   state_id_type start_state;
   state_id_type end_state;
   count_type    state_count;
   set_type      result_set;
   modport source (output valid, status, start_state, end_state, state_count, result_set,
                   input ready);
   modport sink (input valid, status, start_state, end_state, state_count, result_set,
                 output ready);
endinterface

FILE: design/tnfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tnfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: design/thompson_nfa_builder_and_closure.sv
// Top level: Thompson NFA builder with a sequencer over shared edge memories.
// A closure query sweeps the epsilon memory once per growth step, plus a final sweep with no
// growth; a move query first sweeps the symbol memory, then runs a closure on its result.
// One item at a time; the next beat is taken in the cycle after the response is loaded.
// Reset is synchronous and active high; a clear item empties the NFA and stack likewise.
module thompson_nfa_builder_and_closure (
   input logic       clock,
   input logic       reset,
   tnfa_req_if.sink  req_if,
   tnfa_rsp_if.source rsp_if
);
   import tnfa_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEC   = 4'd1;
   localparam logic [3:0] S_POPA  = 4'd2;
   localparam logic [3:0] S_POPB  = 4'd3;
   localparam logic [3:0] S_PLAN  = 4'd4;
   localparam logic [3:0] S_ERD   = 4'd5;
   localparam logic [3:0] S_EWR   = 4'd6;
   localparam logic [3:0] S_PUSH  = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_CL    = 4'd9;
   localparam logic [3:0] S_CLEND = 4'd10;
   localparam logic [3:0] S_MV    = 4'd11;
   localparam logic [3:0] S_MVEND = 4'd12;
   localparam logic [3:0] S_RESP  = 4'd13;

   logic [3:0]        state_ff, state_in;
   mode_type          mode_ff, mode_in;
   char_type          ch_ff, ch_in;
   set_type           set_ff, set_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   count_type         alloc_ff, alloc_in;
   logic              esc_ff, esc_in;
   logic              fail_ff, fail_in;
   pair_type          final_ff, final_in;
   logic [MAX_STATES-1:0] eps_vld_ff, eps_vld_in;
   logic [MAX_STATES-1:0] sym_vld_ff, sym_vld_in;
   pair_type          frag_a_ff, frag_a_in;
   pair_type          frag_b_ff, frag_b_in;
   state_id_type      ep_from_ff [4];
   state_id_type      ep_from_in [4];
   state_id_type      ep_to_ff [4];
   state_id_type      ep_to_in [4];
   logic [1:0]        ep_last_ff, ep_last_in;
   logic [1:0]        ep_i_ff, ep_i_in;
   pair_type          push_ff, push_in;
   logic              add2_ff, add2_in;
   status_type        status_ff, status_in;
   set_type           cl_set_ff, cl_set_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic              chg_ff, chg_in;
   logic [IDX_W-1:0]  e_rq_ff, s_rq_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   pair_type          rsp_pair_ff, rsp_pair_in;
   count_type         rsp_count_ff, rsp_count_in;
   set_type           rsp_set_ff, rsp_set_in;

   logic              eps_we;
   logic [IDX_W-1:0]  eps_waddr, eps_raddr;
   set_type           eps_wdata, eps_rdata, eps_row;
   logic              sym_we;
   logic [IDX_W-1:0]  sym_waddr, sym_raddr;
   logic [SYM_W-1:0]  sym_wdata, sym_rdata, sym_row;
   logic              stk_we;
   logic [SP_W-1:0]   stk_waddr, stk_raddr;
   pair_type          stk_wdata, stk_rdata;

   logic [CNT_W:0]    alloc_plus2;
   logic              no_room;
   state_id_type      s0, s1;
   state_id_type      a_first, a_second, b_first, b_second;
   set_type           grown;
   logic              is_op;
   logic              need_two;

   tnfa_ram #(.WIDTH(SET_W), .DEPTH(MAX_STATES)) u_eps (
      .clock(clock), .we(eps_we), .waddr(eps_waddr), .wdata(eps_wdata),
      .raddr(eps_raddr), .rdata(eps_rdata)
   );

   tnfa_ram #(.WIDTH(SYM_W), .DEPTH(MAX_STATES)) u_sym (
      .clock(clock), .we(sym_we), .waddr(sym_waddr), .wdata(sym_wdata),
      .raddr(sym_raddr), .rdata(sym_rdata)
   );

   tnfa_ram #(.WIDTH(PAIR_W), .DEPTH(STACK_DEPTH)) u_stk (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata)
   );

   assign eps_row     = eps_vld_ff[e_rq_ff] ? eps_rdata : '0;
   assign sym_row     = sym_vld_ff[s_rq_ff] ? sym_rdata : '0;
   assign alloc_plus2 = {1'b0, alloc_ff} + (CNT_W+1)'(2);
   assign no_room     = alloc_plus2 > (CNT_W+1)'(MAX_STATES);
   assign s0          = alloc_ff[STATE_W-1:0];
   assign s1          = s0 + STATE_W'(1);
   assign a_first     = frag_a_ff[PAIR_W-1:STATE_W];
   assign a_second    = frag_a_ff[STATE_W-1:0];
   assign b_first     = frag_b_ff[PAIR_W-1:STATE_W];
   assign b_second    = frag_b_ff[STATE_W-1:0];
   assign grown       = cl_set_ff | eps_row;
   assign is_op       = (ch_ff == CH_ALT) || (ch_ff == CH_CAT) || (ch_ff == CH_STAR) ||
                        (ch_ff == CH_PLUS) || (ch_ff == CH_OPT);
   assign need_two    = (ch_ff == CH_ALT) || (ch_ff == CH_CAT);

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.start_state = rsp_pair_ff[PAIR_W-1:STATE_W];
   assign rsp_if.end_state   = rsp_pair_ff[STATE_W-1:0];
   assign rsp_if.state_count = rsp_count_ff;
   assign rsp_if.result_set  = rsp_set_ff;

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      ch_in      = ch_ff;
      set_in     = set_ff;
      lvl_in     = lvl_ff;
      alloc_in   = alloc_ff;
      esc_in     = esc_ff;
      fail_in    = fail_ff;
      final_in   = final_ff;
      eps_vld_in = eps_vld_ff;
      sym_vld_in = sym_vld_ff;
      frag_a_in  = frag_a_ff;
      frag_b_in  = frag_b_ff;
      ep_from_in = ep_from_ff;
      ep_to_in   = ep_to_ff;
      ep_last_in = ep_last_ff;
      ep_i_in    = ep_i_ff;
      push_in    = push_ff;
      add2_in    = add2_ff;
      status_in  = status_ff;
      cl_set_in  = cl_set_ff;
      idx_in     = idx_ff;
      pend_in    = pend_ff;
      chg_in     = chg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pair_in   = rsp_pair_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_set_in    = rsp_set_ff;
      eps_we    = 1'b0;
      eps_waddr = e_rq_ff;
      eps_wdata = eps_row;
      eps_raddr = idx_ff;
      sym_we    = 1'b0;
      sym_waddr = IDX_W'(s0);
      sym_wdata = {1'b1, ch_ff};
      sym_raddr = idx_ff;
      stk_we    = 1'b0;
      stk_waddr = SP_W'(lvl_ff);
      stk_wdata = push_ff;
      stk_raddr = SP_W'(lvl_ff - LVL_W'(1));

      unique case (state_ff) inside
         S_IDLE: begin
            if (req_if.valid) begin
               mode_in  = req_if.mode;
               ch_in    = req_if.token_char;
               set_in   = req_if.state_set & STATE_MASK;
               status_in = ST_OK;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_RESP;
            unique case (mode_ff)
               MODE_CHAR: begin
                  if (fail_ff) begin
                     status_in = ST_FAIL;
                  end else if (!esc_ff && ch_ff == CH_ESC) begin
                     esc_in = 1'b1;
                  end else if (!esc_ff && is_op) begin
                     if (lvl_ff < (need_two ? LVL_W'(2) : LVL_W'(1))) begin
                        status_in = ST_UNDER;
                        fail_in   = 1'b1;
                     end else if (ch_ff != CH_CAT && no_room) begin
                        status_in = ST_STATE_OVF;
                        fail_in   = 1'b1;
                     end else begin
                        lvl_in   = lvl_ff - LVL_W'(1);
                        state_in = S_POPA;
                     end
                  end else begin
                     esc_in = 1'b0;
                     if (no_room) begin
                        status_in = ST_STATE_OVF;
                        fail_in   = 1'b1;
                     end else if (lvl_ff >= LVL_W'(STACK_DEPTH)) begin
                        status_in = ST_STACK_OVF;
                        fail_in   = 1'b1;
                     end else begin
                        push_in = {s0, s1};
                        add2_in = 1'b1;
                        if (!esc_ff && ch_ff == CH_EPS) begin
                           ep_from_in[0] = s0;
                           ep_to_in[0]   = s1;
                           ep_last_in    = 2'd0;
                           ep_i_in       = 2'd0;
                           state_in      = S_ERD;
                        end else begin
                           sym_we = 1'b1;
                           sym_vld_in[IDX_W'(s0)] = 1'b1;
                           state_in = S_PUSH;
                        end
                     end
                  end
               end
               MODE_FINISH: begin
                  esc_in = 1'b0;
                  if (fail_ff || lvl_ff != LVL_W'(1)) begin
                     fail_in   = 1'b1;
                     status_in = ST_FAIL;
                  end else begin
                     lvl_in   = '0;
                     state_in = S_FIN;
                  end
               end
               MODE_CLEAR: begin
                  lvl_in     = '0;
                  alloc_in   = '0;
                  esc_in     = 1'b0;
                  fail_in    = 1'b0;
                  final_in   = '0;
                  eps_vld_in = '0;
                  sym_vld_in = '0;
               end
               MODE_CLOS: begin
                  cl_set_in = set_ff;
                  idx_in    = '0;
                  pend_in   = 1'b0;
                  chg_in    = 1'b0;
                  state_in  = S_CL;
               end
               MODE_MOVE: begin
                  cl_set_in = '0;
                  idx_in    = '0;
                  pend_in   = 1'b0;
                  state_in  = S_MV;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_POPA: begin
            frag_a_in = stk_rdata;
            if (need_two) begin
               lvl_in   = lvl_ff - LVL_W'(1);
               state_in = S_POPB;
            end else begin
               state_in = S_PLAN;
            end
         end
         S_POPB: begin
            frag_b_in = stk_rdata;
            state_in  = S_PLAN;
         end
         S_PLAN: begin
            ep_i_in  = 2'd0;
            push_in  = {s0, s1};
            add2_in  = 1'b1;
            state_in = S_ERD;
            case (ch_ff)
               CH_CAT: begin
                  ep_from_in[0] = b_second; ep_to_in[0] = a_first;
                  ep_last_in    = 2'd0;
                  push_in       = {b_first, a_second};
                  add2_in       = 1'b0;
               end
               CH_ALT: begin
                  ep_from_in[0] = s0;       ep_to_in[0] = a_first;
                  ep_from_in[1] = s0;       ep_to_in[1] = b_first;
                  ep_from_in[2] = a_second; ep_to_in[2] = s1;
                  ep_from_in[3] = b_second; ep_to_in[3] = s1;
                  ep_last_in    = 2'd3;
               end
               CH_STAR: begin
                  ep_from_in[0] = s0;       ep_to_in[0] = s1;
                  ep_from_in[1] = s0;       ep_to_in[1] = a_first;
                  ep_from_in[2] = a_second; ep_to_in[2] = s1;
                  ep_from_in[3] = a_second; ep_to_in[3] = a_first;
                  ep_last_in    = 2'd3;
               end
               CH_PLUS: begin
                  ep_from_in[0] = s0;       ep_to_in[0] = a_first;
                  ep_from_in[1] = a_second; ep_to_in[1] = s1;
                  ep_from_in[2] = a_second; ep_to_in[2] = a_first;
                  ep_last_in    = 2'd2;
               end
               default: begin
                  ep_from_in[0] = s0;       ep_to_in[0] = a_first;
                  ep_from_in[1] = a_second; ep_to_in[1] = s1;
                  ep_from_in[2] = a_first;  ep_to_in[2] = a_second;
                  ep_last_in    = 2'd2;
               end
            endcase
         end
         S_ERD: begin
            eps_raddr = IDX_W'(ep_from_ff[ep_i_ff]);
            state_in  = S_EWR;
         end
         S_EWR: begin
            eps_we    = 1'b1;
            eps_wdata = eps_row | (SET_W'(1) << ep_to_ff[ep_i_ff]);
            eps_vld_in[e_rq_ff] = 1'b1;
            if (ep_i_ff == ep_last_ff) begin
               state_in = S_PUSH;
            end else begin
               ep_i_in  = ep_i_ff + 2'd1;
               state_in = S_ERD;
            end
         end
         S_PUSH: begin
            stk_we   = 1'b1;
            lvl_in   = lvl_ff + LVL_W'(1);
            alloc_in = add2_ff ? alloc_plus2[CNT_W-1:0] : alloc_ff;
            state_in = S_RESP;
         end
         S_FIN: begin
            final_in = stk_rdata;
            state_in = S_RESP;
         end
         S_CL, S_CLEND: begin
            pend_in = (state_ff == S_CL);
            if (pend_ff && cl_set_ff[e_rq_ff]) begin
               cl_set_in = grown;
               if (grown != cl_set_ff) begin
                  chg_in = 1'b1;
               end
            end
            if (state_ff == S_CL) begin
               if (idx_ff == IDX_W'(MAX_STATES - 1)) begin
                  state_in = S_CLEND;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else if (chg_in) begin
               idx_in   = '0;
               chg_in   = 1'b0;
               state_in = S_CL;
            end else begin
               state_in = S_RESP;
            end
         end
         S_MV, S_MVEND: begin
            pend_in = (state_ff == S_MV);
            if (pend_ff && set_ff[s_rq_ff] && sym_row == {1'b1, ch_ff}) begin
               cl_set_in[s_rq_ff + IDX_W'(1)] = 1'b1;
            end
            if (state_ff == S_MV) begin
               if (idx_ff == IDX_W'(MAX_STATES - 2)) begin
                  state_in = S_MVEND;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               idx_in   = '0;
               chg_in   = 1'b0;
               state_in = S_CL;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pair_in   = final_ff;
               rsp_count_in  = alloc_ff;
               rsp_set_in    = (mode_ff == MODE_CLOS || mode_ff == MODE_MOVE) ? cl_set_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_ff       <= '0;
         alloc_ff     <= '0;
         esc_ff       <= 1'b0;
         fail_ff      <= 1'b0;
         final_ff     <= '0;
         eps_vld_ff   <= '0;
         sym_vld_ff   <= '0;
         pend_ff      <= 1'b0;
         chg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         alloc_ff     <= alloc_in;
         esc_ff       <= esc_in;
         fail_ff      <= fail_in;
         final_ff     <= final_in;
         eps_vld_ff   <= eps_vld_in;
         sym_vld_ff   <= sym_vld_in;
         pend_ff      <= pend_in;
         chg_ff       <= chg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      ch_ff         <= ch_in;
      set_ff        <= set_in;
      frag_a_ff     <= frag_a_in;
      frag_b_ff     <= frag_b_in;
      ep_from_ff    <= ep_from_in;
      ep_to_ff      <= ep_to_in;
      ep_last_ff    <= ep_last_in;
      ep_i_ff       <= ep_i_in;
      push_ff       <= push_in;
      add2_ff       <= add2_in;
      status_ff     <= status_in;
      cl_set_ff     <= cl_set_in;
      idx_ff        <= idx_in;
      e_rq_ff       <= eps_raddr;
      s_rq_ff       <= sym_raddr;
      rsp_status_ff <= rsp_status_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_set_ff    <= rsp_set_in;
   end

`include "thompson_nfa_builder_and_closure_macros.svh"

   `TNFA_ASSERT_NOW(a_lvl_bound, 1'b1, lvl_ff <= LVL_W'(STACK_DEPTH), "stack level past depth")
   `TNFA_ASSERT_NOW(a_alloc_pairs, 1'b1, !alloc_ff[0] && alloc_ff <= CNT_W'(MAX_STATES), "bad state count")
   `TNFA_ASSERT_NXT(a_accept_busy, req_if.valid && req_if.ready, state_ff == S_DEC, "beat taken but no decode")
   `TNFA_ASSERT_NXT(a_cl_grow, state_ff == S_CL, (cl_set_ff & $past(cl_set_ff)) == $past(cl_set_ff), "closure set shrank")
endmodule
